// ===== hw/rtl/mipsx_pkg.sv =====
// ----------------------------------------------------------------------------
// mipsx_pkg
// Shared types, opcode and function codes for the MIPS32 subset executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mipsx_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  localparam logic [4:0]  REG_V0    = 5'd2;
  localparam logic [4:0]  REG_RA    = 5'd31;
  localparam logic [31:0] HALT_CODE = 32'h0000_000a;

  typedef enum logic [1:0] {
    MD_MULT,
    MD_MULTU,
    MD_DIV,
    MD_DIVU
  } md_op_e;

  typedef enum logic [2:0] {
    MEM_LB,
    MEM_LH,
    MEM_LW,
    MEM_LBU,
    MEM_LHU,
    MEM_SB,
    MEM_SH,
    MEM_SW
  } mem_op_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] instruction;
    logic [9:0]  load_index;
    logic [31:0] load_value;
  } in_t;

  typedef struct packed {
    logic [31:0] pc_next;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [9:0]  mem_index;
    logic [31:0] mem_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        halted;
  } out_t;

  // decoded and executed view of one instruction
  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] hi_n;
    logic [31:0] lo_n;
    logic        halt_set;
    logic        md;
    md_op_e      md_op;
    logic        mem;
    mem_op_e     mem_op;
    logic [31:0] ea;
  } exec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mipsx_ram.sv =====
// ----------------------------------------------------------------------------
// mipsx_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mipsx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mipsx_muldiv.sv =====
// ----------------------------------------------------------------------------
// mipsx_muldiv
// Iterative multiply / divide unit: one bit per cycle, 32 steps plus a sign
// fix-up step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mipsx_muldiv (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire mipsx_pkg::md_op_e  op_i,
  input  wire logic [31:0]        a_i,
  input  wire logic [31:0]        b_i,
  output      logic               done_o,
  output      logic [31:0]        hi_o,
  output      logic [31:0]        lo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [31:0] acc_hi_q, acc_lo_q, opnd_q;
  logic        div_q, qneg_q, rneg_q;

  logic        sgn;
  logic [31:0] ma, mb;
  logic [32:0] mul_sum, div_sh, div_diff;
  logic        div_ge;
  logic [63:0] prod, prod_fix;

  always_comb begin
    sgn      = (op_i == mipsx_pkg::MD_MULT) || (op_i == mipsx_pkg::MD_DIV);
    ma       = (sgn && a_i[31]) ? (32'd0 - a_i) : a_i;
    mb       = (sgn && b_i[31]) ? (32'd0 - b_i) : b_i;
    mul_sum  = {1'b0, acc_hi_q} + (acc_lo_q[0] ? {1'b0, opnd_q} : 33'd0);
    div_sh   = {acc_hi_q, acc_lo_q[31]};
    div_diff = div_sh - {1'b0, opnd_q};
    div_ge   = !div_diff[32];
    prod     = {acc_hi_q, acc_lo_q};
    prod_fix = qneg_q ? (64'd0 - prod) : prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q[5]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q    <= (op_i == mipsx_pkg::MD_DIV) || (op_i == mipsx_pkg::MD_DIVU);
      qneg_q   <= sgn && (a_i[31] ^ b_i[31]);
      rneg_q   <= sgn && a_i[31];
      acc_hi_q <= '0;
      if ((op_i == mipsx_pkg::MD_DIV) || (op_i == mipsx_pkg::MD_DIVU)) begin
        acc_lo_q <= ma;
        opnd_q   <= mb;
      end else begin
        acc_lo_q <= mb;
        opnd_q   <= ma;
      end
    end else if (busy_q) begin
      if (cnt_q[5]) begin
        if (div_q) begin
          lo_o <= qneg_q ? (32'd0 - acc_lo_q) : acc_lo_q;
          hi_o <= rneg_q ? (32'd0 - acc_hi_q) : acc_hi_q;
        end else begin
          lo_o <= prod_fix[31:0];
          hi_o <= prod_fix[63:32];
        end
      end else if (div_q) begin
        acc_hi_q <= div_ge ? div_diff[31:0] : div_sh[31:0];
        acc_lo_q <= {acc_lo_q[30:0], div_ge};
      end else begin
        acc_hi_q <= mul_sum[32:1];
        acc_lo_q <= {mul_sum[0], acc_lo_q[31:1]};
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mipsx_alu.sv =====
// ----------------------------------------------------------------------------
// mipsx_alu
// Decode and combinational execute: ALU, shifts, compares, branch and jump
// targets, HI/LO moves, effective address, and the class of long operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mipsx_alu (
  input  wire logic [31:0]       instr_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  input  wire logic [31:0]       pc_i,
  input  wire logic [31:0]       hi_i,
  input  wire logic [31:0]       lo_i,
  output      mipsx_pkg::exec_t  ex_o
);

  always_comb begin
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sh;
    logic [31:0] zimm, simm, pc4, target;
    mipsx_pkg::exec_t ex;

    op     = instr_i[31:26];
    fn     = instr_i[5:0];
    rt     = instr_i[20:16];
    rd     = instr_i[15:11];
    sh     = instr_i[10:6];
    zimm   = {16'd0, instr_i[15:0]};
    simm   = {{16{instr_i[15]}}, instr_i[15:0]};
    pc4    = pc_i + 32'd4;
    target = pc4 + {simm[29:0], 2'b00};

    ex        = '0;
    ex.npc    = pc4;
    ex.hi_n   = hi_i;
    ex.lo_n   = lo_i;
    ex.ea     = a_i + simm;
    ex.md_op  = mipsx_pkg::MD_MULT;
    ex.mem_op = mipsx_pkg::MEM_LW;

    case (op)
      mipsx_pkg::OP_SPECIAL: begin
        ex.widx = rd;
        case (fn)
          mipsx_pkg::FN_SLL:  begin ex.wr = 1'b1; ex.wval = b_i << sh; end
          mipsx_pkg::FN_SRL:  begin ex.wr = 1'b1; ex.wval = b_i >> sh; end
          mipsx_pkg::FN_SRA:  begin ex.wr = 1'b1; ex.wval = $signed(b_i) >>> sh; end
          mipsx_pkg::FN_SLLV: begin ex.wr = 1'b1; ex.wval = b_i << a_i[4:0]; end
          mipsx_pkg::FN_SRLV: begin ex.wr = 1'b1; ex.wval = b_i >> a_i[4:0]; end
          mipsx_pkg::FN_SRAV: begin
            ex.wr = 1'b1; ex.wval = $signed(b_i) >>> a_i[4:0];
          end
          mipsx_pkg::FN_JR:   ex.npc = a_i;
          mipsx_pkg::FN_JALR: begin ex.wr = 1'b1; ex.wval = pc4; ex.npc = a_i; end
          // port A carries $v0 for a syscall
          mipsx_pkg::FN_SYSCALL: ex.halt_set = (a_i == mipsx_pkg::HALT_CODE);
          mipsx_pkg::FN_MFHI: begin ex.wr = 1'b1; ex.wval = hi_i; end
          mipsx_pkg::FN_MTHI: ex.hi_n = a_i;
          mipsx_pkg::FN_MFLO: begin ex.wr = 1'b1; ex.wval = lo_i; end
          mipsx_pkg::FN_MTLO: ex.lo_n = a_i;
          mipsx_pkg::FN_MULT:  begin ex.md = 1'b1; ex.md_op = mipsx_pkg::MD_MULT; end
          mipsx_pkg::FN_MULTU: begin ex.md = 1'b1; ex.md_op = mipsx_pkg::MD_MULTU; end
          mipsx_pkg::FN_DIV:   begin ex.md = (b_i != 32'd0); ex.md_op = mipsx_pkg::MD_DIV; end
          mipsx_pkg::FN_DIVU:  begin ex.md = (b_i != 32'd0); ex.md_op = mipsx_pkg::MD_DIVU; end
          mipsx_pkg::FN_ADD, mipsx_pkg::FN_ADDU: begin ex.wr = 1'b1; ex.wval = a_i + b_i; end
          mipsx_pkg::FN_SUB, mipsx_pkg::FN_SUBU: begin ex.wr = 1'b1; ex.wval = a_i - b_i; end
          mipsx_pkg::FN_AND:  begin ex.wr = 1'b1; ex.wval = a_i & b_i; end
          mipsx_pkg::FN_OR:   begin ex.wr = 1'b1; ex.wval = a_i | b_i; end
          mipsx_pkg::FN_XOR:  begin ex.wr = 1'b1; ex.wval = a_i ^ b_i; end
          mipsx_pkg::FN_NOR:  begin ex.wr = 1'b1; ex.wval = ~(a_i | b_i); end
          mipsx_pkg::FN_SLT:  begin
            ex.wr = 1'b1; ex.wval = {31'd0, $signed(a_i) < $signed(b_i)};
          end
          mipsx_pkg::FN_SLTU: begin ex.wr = 1'b1; ex.wval = {31'd0, a_i < b_i}; end
          default: ;
        endcase
      end
      mipsx_pkg::OP_REGIMM: begin
        ex.widx = mipsx_pkg::REG_RA;
        ex.wval = pc4;
        ex.wr   = (rt == mipsx_pkg::RI_BLTZAL) || (rt == mipsx_pkg::RI_BGEZAL);
        if (rt inside {mipsx_pkg::RI_BLTZ, mipsx_pkg::RI_BLTZAL}) begin
          if (a_i[31]) ex.npc = target;
        end else if (rt inside {mipsx_pkg::RI_BGEZ, mipsx_pkg::RI_BGEZAL}) begin
          if (!a_i[31]) ex.npc = target;
        end
      end
      mipsx_pkg::OP_J, mipsx_pkg::OP_JAL: begin
        ex.npc  = {pc4[31:28], instr_i[25:0], 2'b00};
        ex.wr   = (op == mipsx_pkg::OP_JAL);
        ex.widx = mipsx_pkg::REG_RA;
        ex.wval = pc4;
      end
      mipsx_pkg::OP_BEQ:  if (a_i == b_i) ex.npc = target;
      mipsx_pkg::OP_BNE:  if (a_i != b_i) ex.npc = target;
      mipsx_pkg::OP_BLEZ: if ((a_i == 32'd0) || a_i[31]) ex.npc = target;
      mipsx_pkg::OP_BGTZ: if ((a_i != 32'd0) && !a_i[31]) ex.npc = target;
      mipsx_pkg::OP_ADDI, mipsx_pkg::OP_ADDIU: begin
        ex.wr = 1'b1; ex.widx = rt; ex.wval = ex.ea;
      end
      mipsx_pkg::OP_SLTI: begin
        ex.wr = 1'b1; ex.widx = rt; ex.wval = {31'd0, $signed(a_i) < $signed(simm)};
      end
      mipsx_pkg::OP_SLTIU: begin
        ex.wr = 1'b1; ex.widx = rt; ex.wval = {31'd0, a_i < simm};
      end
      mipsx_pkg::OP_ANDI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a_i & zimm; end
      mipsx_pkg::OP_ORI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a_i | zimm; end
      mipsx_pkg::OP_XORI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a_i ^ zimm; end
      mipsx_pkg::OP_LUI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = {instr_i[15:0], 16'd0}; end
      mipsx_pkg::OP_LB:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_LB;  end
      mipsx_pkg::OP_LH:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_LH;  end
      mipsx_pkg::OP_LW:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_LW;  end
      mipsx_pkg::OP_LBU: begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_LBU; end
      mipsx_pkg::OP_LHU: begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_LHU; end
      mipsx_pkg::OP_SB:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_SB;  end
      mipsx_pkg::OP_SH:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_SH;  end
      mipsx_pkg::OP_SW:  begin ex.mem = 1'b1; ex.mem_op = mipsx_pkg::MEM_SW;  end
      default: ;
    endcase

    // $0 is never written; report nothing then
    if (!ex.wr || (ex.widx == 5'd0)) begin
      ex.wr   = 1'b0;
      ex.widx = '0;
      ex.wval = '0;
    end
    ex_o = ex;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mips32_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// mips32_instruction_executor
// Multicycle executor for a MIPS32 integer subset with internal data memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is either an
// instruction word executed at the current PC (kind 0) or a data memory
// preload (kind 1). Output channel (out_valid_o / out_stall_i / out_data_o):
// exactly one result beat per input beat, in order, with PC, register and
// store write-back, HI/LO and the halt flag as they stand after the item.
// Steps: ALU, branch and jump items go accept, execute, write back, result;
// preloads go accept, write, write back, result; loads and stores add a data
// RAM read and merge after execute; mult/div run on the iterative unit. When
// DATA_WORDS is not a power of two the word index is a remainder by reciprocal
// multiplication, adding the index state to every memory item. One item is in
// flight at a time; the next is taken as soon as the result sits in the output
// register, even while the receiver stalls it. A stalled result holds.
// Reset: PC = RESET_PC, HI = LO = 0, halt clear, all registers read zero
// (per-entry valid bits); data memory is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mips32_instruction_executor #(
  parameter int          DATA_WORDS = 1024,
  parameter logic [31:0] RESET_PC   = 32'h0040_0000
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire mipsx_pkg::in_t   in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      mipsx_pkg::out_t  out_data_o
);

  localparam int          AW   = $clog2(DATA_WORDS);
  localparam bit          POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam logic [29:0] DW30 = 30'(DATA_WORDS);
  // floor(2^32 / DATA_WORDS): quotient estimate is exact or one short
  localparam logic [31:0] RCP  = 32'((64'd1 << 32) / DATA_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EX   = 3'd1;
  localparam logic [2:0] S_MD   = 3'd2;
  localparam logic [2:0] S_IDX  = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MEM  = 3'd5;
  localparam logic [2:0] S_PRE  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;
  // result hand-over shares the write-back code path via done_q
  logic [2:0] state_q, state_d;
  logic       done_q;

  logic [31:0] pc_q, hi_q, lo_q;
  logic        halt_q;
  logic [31:0] rf_vld_q;
  logic        out_valid_q;
  mipsx_pkg::out_t out_q;

  // item registers
  logic        kind_q;
  logic [31:0] instr_q;
  logic [9:0]  lidx_q;
  logic [31:0] lval_q;
  logic [31:0] npc_q, hi_n_q, lo_n_q, wval_q, sval_q, ea_q, b_q;
  logic        halt_n_q, wr_q, st_q, va_q, vb_q;
  logic [4:0]  widx_q;
  logic [9:0]  sidx_q;
  logic [AW-1:0] idx_q;
  mipsx_pkg::mem_op_e mem_op_q;

  // word index remainder
  logic [29:0] rm_x_q, rm_q_q, rm_r_q;
  logic [1:0]  rm_step_q;
  logic [61:0] rm_prod;
  logic [29:0] rm_qd;

  logic        accept;
  logic [4:0]  rf_ra;
  logic [31:0] rf_rdata_a, rf_rdata_b, a_eff, b_eff;
  logic        rf_we;
  mipsx_pkg::exec_t ex;

  logic        md_start, md_done;
  mipsx_pkg::md_op_e md_op;
  logic [31:0] md_a, md_b, md_hi, md_lo;

  logic          dm_we, dm_re;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata, dm_rdata;
  logic [31:0]   lidx32, idx32;

  logic [31:0] wsh, hsh, lane_mask, lane_data, merged, ld_val;
  logic        ld_wr, is_store;

  assign accept     = in_valid_i && (state_q == S_IDLE) && !done_q;
  assign in_stall_o = (state_q != S_IDLE) || done_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rf_ra = ((in_data_i.instruction[31:26] == mipsx_pkg::OP_SPECIAL) &&
                  (in_data_i.instruction[5:0] == mipsx_pkg::FN_SYSCALL))
                 ? mipsx_pkg::REG_V0 : in_data_i.instruction[25:21];
  assign rf_we = (state_q == S_WB) && wr_q;

  // two copies of the register file give the two read ports
  mipsx_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(widx_q),
    .wdata_i(wval_q),
    .re_i   (accept),
    .raddr_i(rf_ra),
    .rdata_o(rf_rdata_a)
  );

  mipsx_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(widx_q),
    .wdata_i(wval_q),
    .re_i   (accept),
    .raddr_i(in_data_i.instruction[20:16]),
    .rdata_o(rf_rdata_b)
  );

  assign a_eff = va_q ? rf_rdata_a : 32'd0;
  assign b_eff = vb_q ? rf_rdata_b : 32'd0;

  mipsx_alu u_alu (
    .instr_i(instr_q),
    .a_i    (a_eff),
    .b_i    (b_eff),
    .pc_i   (pc_q),
    .hi_i   (hi_q),
    .lo_i   (lo_q),
    .ex_o   (ex)
  );

  assign md_start = (state_q == S_EX) && ex.md;
  assign md_op    = ex.md_op;
  assign md_a     = a_eff;
  assign md_b     = b_eff;

  mipsx_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .op_i   (md_op),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .hi_o   (md_hi),
    .lo_o   (md_lo)
  );

  assign rm_prod = 62'(rm_x_q) * 62'(RCP);
  assign rm_qd   = rm_q_q * DW30;

  // load lane extraction and store merge
  always_comb begin
    wsh       = dm_rdata >> {ea_q[1:0], 3'b000};
    hsh       = dm_rdata >> {ea_q[1], 4'b0000};
    is_store  = (mem_op_q == mipsx_pkg::MEM_SB) || (mem_op_q == mipsx_pkg::MEM_SH) ||
                (mem_op_q == mipsx_pkg::MEM_SW);
    ld_wr     = (instr_q[20:16] != 5'd0) && !is_store;
    lane_mask = 32'hffff_ffff;
    lane_data = b_q;
    ld_val    = dm_rdata;
    case (mem_op_q)
      mipsx_pkg::MEM_LB:  ld_val = {{24{wsh[7]}}, wsh[7:0]};
      mipsx_pkg::MEM_LH: begin
        ld_val = {{16{hsh[15]}}, hsh[15:0]};
        // misaligned lh leaves the register alone
        if (ea_q[0]) ld_wr = 1'b0;
      end
      mipsx_pkg::MEM_LW:  ld_val = dm_rdata;
      mipsx_pkg::MEM_LBU: ld_val = {24'd0, wsh[7:0]};
      mipsx_pkg::MEM_LHU: ld_val = {16'd0, hsh[15:0]};
      mipsx_pkg::MEM_SB: begin
        lane_mask = 32'h0000_00ff << {ea_q[1:0], 3'b000};
        lane_data = {24'd0, b_q[7:0]} << {ea_q[1:0], 3'b000};
      end
      mipsx_pkg::MEM_SH: begin
        lane_mask = 32'h0000_ffff << {ea_q[1], 4'b0000};
        lane_data = {16'd0, b_q[15:0]} << {ea_q[1], 4'b0000};
      end
      mipsx_pkg::MEM_SW: begin
        lane_mask = 32'hffff_ffff;
        lane_data = b_q;
      end
      default: ;
    endcase
    merged = (dm_rdata & ~lane_mask) | (lane_data & lane_mask);
  end

  assign lidx32   = {22'd0, lidx_q};
  assign idx32    = 32'(idx_q);
  assign dm_re    = (state_q == S_MRD);
  assign dm_we    = (state_q == S_PRE) || ((state_q == S_MEM) && is_store);
  assign dm_waddr = ((state_q == S_PRE) && POW2) ? lidx32[AW-1:0] : idx_q;
  assign dm_wdata = (state_q == S_PRE) ? lval_q : merged;

  mipsx_ram #(.Width(32), .Depth(DATA_WORDS)) u_dmem (
    .clk_i  (clk_i),
    .we_i   (dm_we),
    .waddr_i(dm_waddr),
    .wdata_i(dm_wdata),
    .re_i   (dm_re),
    .raddr_i(idx_q),
    .rdata_o(dm_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.kind) begin
            state_d = POW2 ? S_PRE : S_IDX;
          end else begin
            state_d = halt_q ? S_WB : S_EX;
          end
        end
      end
      S_EX: begin
        if (ex.md) begin
          state_d = S_MD;
        end else if (ex.mem) begin
          state_d = POW2 ? S_MRD : S_IDX;
        end else begin
          state_d = S_WB;
        end
      end
      S_MD:  if (md_done) state_d = S_WB;
      S_IDX: if (rm_step_q == 2'd2) state_d = kind_q ? S_PRE : S_MRD;
      S_MRD: state_d = S_MEM;
      S_MEM: state_d = S_WB;
      S_PRE: state_d = S_WB;
      S_WB:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      pc_q        <= RESET_PC;
      hi_q        <= '0;
      lo_q        <= '0;
      halt_q      <= 1'b0;
      rf_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_WB) begin
        pc_q   <= npc_q;
        hi_q   <= hi_n_q;
        lo_q   <= lo_n_q;
        halt_q <= halt_n_q;
        if (wr_q) rf_vld_q[widx_q] <= 1'b1;
        done_q <= 1'b1;
      end
      // hand the result over once the output register is free
      if (done_q && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        done_q      <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (done_q && (!out_valid_q || !out_stall_i)) begin
      out_q.pc_next   <= pc_q;
      out_q.reg_write <= wr_q;
      out_q.reg_index <= widx_q;
      out_q.reg_value <= wval_q;
      out_q.mem_write <= st_q;
      out_q.mem_index <= sidx_q;
      out_q.mem_value <= sval_q;
      out_q.hi_value  <= hi_q;
      out_q.lo_value  <= lo_q;
      out_q.halted    <= halt_q;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_q    <= in_data_i.kind;
          instr_q   <= in_data_i.instruction;
          lidx_q    <= in_data_i.load_index;
          lval_q    <= in_data_i.load_value;
          va_q      <= rf_vld_q[rf_ra];
          vb_q      <= rf_vld_q[in_data_i.instruction[20:16]];
          npc_q     <= pc_q;
          hi_n_q    <= hi_q;
          lo_n_q    <= lo_q;
          halt_n_q  <= halt_q;
          wr_q      <= 1'b0;
          widx_q    <= '0;
          wval_q    <= '0;
          st_q      <= 1'b0;
          sidx_q    <= '0;
          sval_q    <= '0;
          rm_x_q    <= {20'd0, in_data_i.load_index};
          rm_step_q <= '0;
        end
      end
      S_EX: begin
        npc_q     <= ex.npc;
        wr_q      <= ex.wr;
        widx_q    <= ex.widx;
        wval_q    <= ex.wval;
        hi_n_q    <= ex.hi_n;
        lo_n_q    <= ex.lo_n;
        halt_n_q  <= halt_q | ex.halt_set;
        ea_q      <= ex.ea;
        b_q       <= b_eff;
        mem_op_q  <= ex.mem_op;
        rm_x_q    <= ex.ea[31:2];
        rm_step_q <= '0;
        if (POW2) idx_q <= ex.ea[AW+1:2];
      end
      S_MD: begin
        if (md_done) begin
          hi_n_q <= md_hi;
          lo_n_q <= md_lo;
        end
      end
      S_IDX: begin
        rm_step_q <= rm_step_q + 2'd1;
        case (rm_step_q)
          2'd0: rm_q_q <= rm_prod[61:32];
          2'd1: rm_r_q <= rm_x_q - rm_qd;
          // estimate may be one short: one conditional subtract
          default: idx_q <= (rm_r_q >= DW30) ? AW'(rm_r_q - DW30) : AW'(rm_r_q);
        endcase
      end
      S_MEM: begin
        if (is_store) begin
          st_q   <= 1'b1;
          sidx_q <= idx32[9:0];
          sval_q <= merged;
        end else if (ld_wr) begin
          wr_q   <= 1'b1;
          widx_q <= instr_q[20:16];
          wval_q <= ld_val;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mipsx_chk.sv =====
// ----------------------------------------------------------------------------
// mipsx_chk
// Port-level checker for the executor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mipsx_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire mipsx_pkg::out_t out_data_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // halt is sticky across result beats
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.halted |=> !out_valid_o || out_data_o.halted)
    else $error("halt flag cleared");

  // $0 is never reported as written
  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reg_write |-> out_data_o.reg_index != 5'd0)
    else $error("write to register zero reported");

  // one item at a time: an accepted beat blocks the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while busy");

endmodule

bind mips32_instruction_executor mipsx_chk u_mipsx_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== tb/mips32_exec_checker.sv =====
// ----------------------------------------------------------------------------
// mips32_exec_checker
// Watches both channels of the executor, predicts each result beat from an
// architectural copy of the machine state and compares the whole beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips32_exec_checker
  import mipsx_pkg::*;
#(
  parameter int          DATA_WORDS = 1024,
  parameter logic [31:0] RESET_PC   = 32'h0040_0000
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_seen_o
);

  logic [31:0] gpr [32];
  logic [31:0] pc_q, hi_q, lo_q;
  logic        halt_q;
  logic [31:0] dmem [DATA_WORDS];
  out_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic put_reg(inout out_t r, input logic [4:0] idx, input logic [31:0] val);
    if (idx != 5'd0) begin
      gpr[idx]    = val;
      r.reg_write = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
    end
  endtask

  task automatic put_mem(inout out_t r, input logic [31:0] ea, input logic [31:0] val,
                         input logic [31:0] mask);
    int unsigned wi;
    wi = (ea >> 2) % DATA_WORDS;
    dmem[wi]    = (dmem[wi] & ~mask) | (val & mask);
    r.mem_write = 1'b1;
    r.mem_index = wi[9:0];
    r.mem_value = dmem[wi];
  endtask

  // architectural effect of one beat
  task automatic execute_beat(input in_t b, output out_t r);
    logic [31:0] ins, a, bv, simm, zimm, ea, word, npc, tgt, lnk;
    logic [5:0]  op;
    logic [4:0]  rs, rt, rd, sh;
    logic [63:0] p;
    logic [31:0] ma, mb, q, rm;
    int unsigned bsh, hsh;
    r = '0;
    if (b.kind) begin
      dmem[b.load_index % DATA_WORDS] = b.load_value;
    end else if (!halt_q) begin
      ins = b.instruction; op = ins[31:26];
      rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sh = ins[10:6];
      a = gpr[rs]; bv = gpr[rt];
      zimm = {16'h0, ins[15:0]}; simm = sext16(ins[15:0]);
      ea = a + simm; word = dmem[(ea >> 2) % DATA_WORDS];
      bsh = ea[1:0] * 8; hsh = ea[1] * 16;
      lnk = pc_q + 32'd4; npc = lnk; tgt = lnk + (simm << 2);
      if (op == OP_SPECIAL) begin
        case (ins[5:0])
          FN_SLL:  put_reg(r, rd, bv << sh);
          FN_SRL:  put_reg(r, rd, bv >> sh);
          FN_SRA:  put_reg(r, rd, $signed(bv) >>> sh);
          FN_SLLV: put_reg(r, rd, bv << a[4:0]);
          FN_SRLV: put_reg(r, rd, bv >> a[4:0]);
          FN_SRAV: put_reg(r, rd, $signed(bv) >>> a[4:0]);
          FN_JR:   npc = a;
          FN_JALR: begin put_reg(r, rd, lnk); npc = a; end
          FN_SYSCALL: if (gpr[REG_V0] == HALT_CODE) halt_q = 1'b1;
          FN_MFHI: put_reg(r, rd, hi_q);
          FN_MTHI: hi_q = a;
          FN_MFLO: put_reg(r, rd, lo_q);
          FN_MTLO: lo_q = a;
          FN_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{bv[31]}}, bv});
            {hi_q, lo_q} = p;
          end
          FN_MULTU: begin p = {32'h0, a} * {32'h0, bv}; {hi_q, lo_q} = p; end
          FN_DIV: if (bv != 0) begin
            ma = a[31] ? -a : a; mb = bv[31] ? -bv : bv;
            q = ma / mb; rm = ma % mb;
            if (a[31] ^ bv[31]) q = -q;
            if (a[31]) rm = -rm;
            lo_q = q; hi_q = rm;
          end
          FN_DIVU: if (bv != 0) begin lo_q = a / bv; hi_q = a % bv; end
          FN_ADD, FN_ADDU: put_reg(r, rd, a + bv);
          FN_SUB, FN_SUBU: put_reg(r, rd, a - bv);
          FN_AND:  put_reg(r, rd, a & bv);
          FN_OR:   put_reg(r, rd, a | bv);
          FN_XOR:  put_reg(r, rd, a ^ bv);
          FN_NOR:  put_reg(r, rd, ~(a | bv));
          FN_SLT:  put_reg(r, rd, {31'h0, $signed(a) < $signed(bv)});
          FN_SLTU: put_reg(r, rd, {31'h0, a < bv});
          default: ;
        endcase
      end else begin
        case (op)
          OP_REGIMM: begin
            if (rt == RI_BLTZ || rt == RI_BLTZAL) begin
              if (rt == RI_BLTZAL) put_reg(r, REG_RA, lnk);
              if (a[31]) npc = tgt;
            end else if (rt == RI_BGEZ || rt == RI_BGEZAL) begin
              if (rt == RI_BGEZAL) put_reg(r, REG_RA, lnk);
              if (!a[31]) npc = tgt;
            end
          end
          OP_J, OP_JAL: begin
            if (op == OP_JAL) put_reg(r, REG_RA, lnk);
            npc = {lnk[31:28], ins[25:0], 2'b00};
          end
          OP_BEQ:  if (a == bv) npc = tgt;
          OP_BNE:  if (a != bv) npc = tgt;
          OP_BLEZ: if (a == 0 || a[31]) npc = tgt;
          OP_BGTZ: if (a != 0 && !a[31]) npc = tgt;
          OP_ADDI, OP_ADDIU: put_reg(r, rt, ea);
          OP_SLTI:  put_reg(r, rt, {31'h0, $signed(a) < $signed(simm)});
          OP_SLTIU: put_reg(r, rt, {31'h0, a < simm});
          OP_ANDI:  put_reg(r, rt, a & zimm);
          OP_ORI:   put_reg(r, rt, a | zimm);
          OP_XORI:  put_reg(r, rt, a ^ zimm);
          OP_LUI:   put_reg(r, rt, zimm << 16);
          OP_LB:  put_reg(r, rt, {{24{word[bsh+7]}}, word[bsh +: 8]});
          OP_LH:  if (!ea[0]) put_reg(r, rt, sext16(word[hsh +: 16]));
          OP_LW:  put_reg(r, rt, word);
          OP_LBU: put_reg(r, rt, {24'h0, word[bsh +: 8]});
          OP_LHU: put_reg(r, rt, {16'h0, word[hsh +: 16]});
          OP_SB:  put_mem(r, ea, (bv & 32'hff) << bsh, 32'hff << bsh);
          OP_SH:  put_mem(r, ea, (bv & 32'hffff) << hsh, 32'hffff << hsh);
          OP_SW:  put_mem(r, ea, bv, 32'hffff_ffff);
          default: ;
        endcase
      end
      pc_q = npc;
    end
    r.pc_next  = pc_q;
    r.hi_value = hi_q;
    r.lo_value = lo_q;
    r.halted   = halt_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r, got;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      pc_q = RESET_PC; hi_q = '0; lo_q = '0; halt_q = 1'b0;
      expected_q.delete();
      fail_count_o   <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: result beat with none expected: %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count_o < 10)
              $display("ERROR: mismatch\n  expected %p\n  actual   %p", exp_r, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        execute_beat(in_data_i, exp_r);
        expected_q.push_back(exp_r);
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction and preload beats into the executor with random idling
// and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mipsx_pkg::*;

  localparam int          DATA_WORDS = 1024;
  localparam logic [31:0] RESET_PC   = 32'h0040_0000;
  localparam int          CYCLE_LIMIT = 1000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;
  int   fail_count, pending, results_seen, cycle_cnt;
  logic idle_free, hold_off;
  bit   written [DATA_WORDS];
  int   n_instr, n_preload;

  mips32_instruction_executor #(.DATA_WORDS(DATA_WORDS), .RESET_PC(RESET_PC)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  mips32_exec_checker #(.DATA_WORDS(DATA_WORDS), .RESET_PC(RESET_PC)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ERROR: timeout, %0d results outstanding", pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(negedge clk_i) begin
    if (hold_off)       out_stall_i <= 1'b1;
    else if (idle_free) out_stall_i <= 1'b0;
    else                out_stall_i <= ($urandom_range(99) < 26);
  end

  function automatic logic [31:0] r_type(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // valid is dropped by the next idle cycle or by drain
  task automatic send(input in_t b);
    while (!idle_free && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_instr(input logic [31:0] ins);
    in_t b;
    b = '{kind: 1'b0, instruction: ins, load_index: 10'($urandom),
          load_value: $urandom};
    n_instr++;
    send(b);
  endtask

  task automatic preload(input logic [9:0] idx, input logic [31:0] val);
    in_t b;
    b = '{kind: 1'b1, instruction: $urandom, load_index: idx, load_value: val};
    written[idx] = 1'b1;
    n_preload++;
    send(b);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // random instruction; memory ops use $0 as base so addresses are known
  function automatic logic [31:0] rand_instr();
    logic [5:0]  ops [] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
                            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
                            OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
                            OP_SB, OP_SH, OP_SW};
    logic [5:0]  fns [] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                            FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
                            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
                            FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
                            FN_SLTU};
    logic [31:0] w;
    logic [5:0]  op;
    logic [15:0] off;
    w = $urandom;
    // noise, mostly unknown codes; top opcode bit clear keeps memory ops out
    if ($urandom_range(9) == 0) return {1'b0, w[30:0]};
    if ($urandom_range(2) == 0) begin
      w[31:26] = OP_SPECIAL;
      w[5:0]   = fns[$urandom_range(fns.size() - 1)];
      if (w[5:0] == FN_SYSCALL && $urandom_range(3) != 0) w[5:0] = FN_ADDU;
      return w;
    end
    op = ops[$urandom_range(ops.size() - 1)];
    w[31:26] = op;
    if (op >= OP_LB) begin
      off = {4'h0, w[11:0]};
      if (op < OP_SB && !written[off[11:2]]) off[11:2] = 10'd0;  // word 0 preloaded
      if (op == OP_SB || op == OP_SH) begin
        if (!written[off[11:2]]) off[11:2] = 10'd0;
      end
      if (op == OP_SW) written[off[11:2]] = 1'b1;
      w[25:21] = 5'd0;
      w[15:0]  = off;
    end
    return w;
  endfunction

  initial begin
    logic [31:0] ext [] = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1};
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    idle_free = 1'b0; hold_off = 1'b0; cycle_cnt = 0; n_instr = 0; n_preload = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, special cases of division and halfword alignment
    preload(10'd0, 32'h8081_7f80);
    preload(10'h3ff, 32'hffff_ffff);
    send_instr(i_type(OP_LUI, 5'd0, 5'd8, 16'h8000));
    send_instr(i_type(OP_ADDIU, 5'd0, 5'd9, 16'hffff));
    send_instr(r_type(5'd8, 5'd9, 5'd0, 5'd0, FN_DIV));          // overflow case
    send_instr(r_type(5'd8, 5'd0, 5'd0, 5'd0, FN_DIVU));         // divide by zero
    send_instr(r_type(5'd8, 5'd9, 5'd0, 5'd0, FN_MULT));
    send_instr(r_type(5'd9, 5'd9, 5'd0, 5'd0, FN_MULTU));
    send_instr(i_type(OP_ANDI, 5'd9, 5'd10, 16'hffff));
    send_instr(i_type(OP_XORI, 5'd9, 5'd11, 16'h8000));
    send_instr(i_type(OP_LH, 5'd0, 5'd12, 16'h0001));            // misaligned lh
    send_instr(i_type(OP_LHU, 5'd0, 5'd12, 16'h0003));
    send_instr(i_type(OP_LB, 5'd0, 5'd13, 16'h0002));
    send_instr(i_type(OP_SB, 5'd0, 5'd9, 16'h0ffd));
    send_instr(i_type(OP_SH, 5'd0, 5'd8, 16'h0003));
    send_instr(r_type(5'd8, 5'd0, 5'd31, 5'd0, FN_JALR));
    send_instr({OP_JAL, 26'h3ff_ffff});
    send_instr(r_type(5'd0, 5'd9, 5'd14, 5'd31, FN_SRA));
    send_instr(i_type(OP_REGIMM, 5'd9, RI_BGEZAL, 16'h8000));
    send_instr(i_type(OP_REGIMM, 5'd9, RI_BLTZAL, 16'h7fff));
    drain();

    // random body, with one long receiver hold-off
    for (int i = 0; i < 1750; i++) begin
      if (i == 300) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 600) idle_free = 1'b1;
      if (i == 800) idle_free = 1'b0;
      if (i == 1000) drain();  // sender pause until everything is back
      if (i % 250 == 0) begin
        // refill registers with extremes so arithmetic corners recur
        foreach (ext[k]) begin
          send_instr(i_type(OP_LUI, 5'd0, 5'(k + 3), ext[k][31:16]));
          send_instr(i_type(OP_ORI, 5'(k + 3), 5'(k + 3), ext[k][15:0]));
        end
      end
      if ($urandom_range(7) == 0) preload(10'($urandom), $urandom);
      else send_instr(rand_instr());
    end

    // halt, then a few ignored instructions and a preload, which still lands
    send_instr(i_type(OP_ADDIU, 5'd0, REG_V0, 16'h000a));
    send_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    send_instr(i_type(OP_ADDIU, 5'd0, 5'd5, 16'h1234));
    preload(10'd7, 32'hdead_beef);
    send_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    drain();
    repeat (50) @(negedge clk_i);

    $display("Covered %0d instruction beats and %0d preload beats, %0d results checked.",
             n_instr, n_preload, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mipsx_pkg.sv
hw/rtl/mipsx_ram.sv
hw/rtl/mipsx_muldiv.sv
hw/rtl/mipsx_alu.sv
hw/rtl/mips32_instruction_executor.sv
hw/rtl/mipsx_chk.sv
tb/mips32_exec_checker.sv
tb/tb_top.sv
